// ----- src/cbc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the color blob centroid unit
package cbc_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // field widths
  localparam int COLOR_W = 8;
  localparam int COORD_W = 10;
  localparam int RATIO_W = 4;

  // accumulator sizing follows from the frame limits
  localparam longint unsigned MATCH_CAP = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam int COUNT_W = $clog2(MATCH_CAP + 1);
  localparam int SUM_W   = $clog2(MATCH_CAP * ((longint'(1) << COORD_W) - 1) + 1);

  // divider sizing
  localparam int DIV_W  = COUNT_W + COORD_W;
  localparam int STEP_W = $clog2(COORD_W);

  // queue of frame totals
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_RATIO = CFG_ADDR_W'(0);
  localparam logic [RATIO_W-1:0]    RATIO_RESET    = RATIO_W'(5);

  // input request
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_pixel;
  } pixel_t;

  // result request
  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] centre_x;
    logic [COORD_W-1:0] centre_y;
  } centroid_t;

  // totals of one frame
  typedef struct packed {
    logic [SUM_W-1:0]   sum_column;
    logic [SUM_W-1:0]   sum_row;
    logic [COUNT_W-1:0] match_count;
  } totals_t;

  // write side of the totals queue
  typedef struct packed {
    logic    valid;
    totals_t data;
  } q_wr_t;

  // status of the totals queue
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- src/cbc_front.sv -----
`timescale 1ns / 1ps
// pixel classifier and per-frame accumulators
module cbc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cbc_pkg::RATIO_W-1:0] ratio,
  input  logic                       push,
  input  cbc_pkg::pixel_t            in_data,
  input  cbc_pkg::q_stat_t           q_stat,
  output logic                       full,
  output cbc_pkg::q_wr_t             q_wr
);

  logic [cbc_pkg::SUM_W-1:0]   sum_col_r, sum_col_nxt;
  logic [cbc_pkg::SUM_W-1:0]   sum_row_r, sum_row_nxt;
  logic [cbc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [cbc_pkg::COLOR_W+cbc_pkg::RATIO_W-1:0] lim_red, lim_green;
  logic accept, match, take;

  // a frame's totals need a free queue slot, so stall on a full queue
  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  // threshold test with exact products
  assign lim_red   = ratio * in_data.red;
  assign lim_green = ratio * in_data.green;
  assign match = ((cbc_pkg::COLOR_W+cbc_pkg::RATIO_W)'(in_data.blue) > lim_red) &&
                 ((cbc_pkg::COLOR_W+cbc_pkg::RATIO_W)'(in_data.blue) > lim_green);

  // matches beyond the frame capacity are dropped
  assign take = match && (count_r != cbc_pkg::COUNT_W'(cbc_pkg::MATCH_CAP));

  // totals including the current pixel
  always_comb begin
    sum_col_nxt = sum_col_r;
    sum_row_nxt = sum_row_r;
    count_nxt   = count_r;
    if (take) begin
      sum_col_nxt = sum_col_r + cbc_pkg::SUM_W'(in_data.column);
      sum_row_nxt = sum_row_r + cbc_pkg::SUM_W'(in_data.row);
      count_nxt   = count_r + cbc_pkg::COUNT_W'(1);
    end
  end

  // hand the frame totals to the back end on the last pixel
  assign q_wr.valid            = accept && in_data.last_pixel;
  assign q_wr.data.sum_column  = sum_col_nxt;
  assign q_wr.data.sum_row     = sum_row_nxt;
  assign q_wr.data.match_count = count_nxt;

  // accumulators, cleared at the end of each frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_col_r <= '0;
      sum_row_r <= '0;
      count_r   <= '0;
    end else if (accept) begin
      if (in_data.last_pixel) begin
        sum_col_r <= '0;
        sum_row_r <= '0;
        count_r   <= '0;
      end else begin
        sum_col_r <= sum_col_nxt;
        sum_row_r <= sum_row_nxt;
        count_r   <= count_nxt;
      end
    end
  end

endmodule

// ----- src/cbc_queue.sv -----
`timescale 1ns / 1ps
// short queue of frame totals between front and back end
module cbc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  cbc_pkg::q_wr_t    q_wr,
  input  logic              rd_en,
  output cbc_pkg::totals_t  rd_data,
  output cbc_pkg::q_stat_t  q_stat
);

  cbc_pkg::totals_t mem_r [cbc_pkg::Q_DEPTH];
  logic [cbc_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [cbc_pkg::QCNT_W-1:0] cnt_r;
  logic do_wr, do_rd;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == cbc_pkg::QCNT_W'(cbc_pkg::Q_DEPTH));
  assign do_wr = q_wr.valid && !q_stat.full;
  assign do_rd = rd_en && !q_stat.empty;
  assign rd_data = mem_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= q_wr.data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == cbc_pkg::QPTR_W'(cbc_pkg::Q_DEPTH - 1)) ?
                    '0 : wr_ptr_r + cbc_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == cbc_pkg::QPTR_W'(cbc_pkg::Q_DEPTH - 1)) ?
                    '0 : rd_ptr_r + cbc_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + cbc_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - cbc_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ----- src/cbc_back.sv -----
`timescale 1ns / 1ps
// centroid divider and result register
module cbc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cbc_pkg::q_stat_t  q_stat,
  input  cbc_pkg::totals_t  rd_data,
  output logic              rd_en,
  input  logic              pop,
  output logic              empty,
  output cbc_pkg::centroid_t out_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  state_t state_r;
  logic [cbc_pkg::DIV_W-1:0]   rem_x_r, rem_y_r, dsh_r;
  logic [cbc_pkg::DIV_W-1:0]   sub_x, sub_y;
  logic [cbc_pkg::COORD_W-1:0] q_x_r, q_y_r;
  logic [cbc_pkg::STEP_W-1:0]  step_r;
  logic                        found_r;
  logic                        out_valid_r;
  cbc_pkg::centroid_t          out_r;
  logic ge_x, ge_y, out_free;

  assign rd_en    = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_free = !out_valid_r || pop;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  // one restoring step per cycle on both coordinates
  assign ge_x  = rem_x_r >= dsh_r;
  assign ge_y  = rem_y_r >= dsh_r;
  assign sub_x = rem_x_r - dsh_r;
  assign sub_y = rem_y_r - dsh_r;

  // divider sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: loaded when a quotient is done, cleared when popped
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            rem_x_r <= cbc_pkg::DIV_W'(rd_data.sum_column);
            rem_y_r <= cbc_pkg::DIV_W'(rd_data.sum_row);
            dsh_r   <= cbc_pkg::DIV_W'(rd_data.match_count) << (cbc_pkg::COORD_W - 1);
            found_r <= (rd_data.match_count != '0);
            q_x_r   <= '0;
            q_y_r   <= '0;
            step_r  <= cbc_pkg::STEP_W'(cbc_pkg::COORD_W - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ge_x) begin
            rem_x_r <= sub_x;
          end
          if (ge_y) begin
            rem_y_r <= sub_y;
          end
          q_x_r  <= {q_x_r[cbc_pkg::COORD_W-2:0], ge_x};
          q_y_r  <= {q_y_r[cbc_pkg::COORD_W-2:0], ge_y};
          dsh_r  <= dsh_r >> 1;
          step_r <= step_r - cbc_pkg::STEP_W'(1);
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // empty frame reports zero coordinates
          if (out_free) begin
            out_r.found    <= found_r;
            out_r.centre_x <= found_r ? q_x_r : '0;
            out_r.centre_y <= found_r ? q_y_r : '0;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/color_blob_centroid_unit.sv -----
`timescale 1ns / 1ps
// color blob centroid unit: one pixel per cycle unless full, one centroid per frame
// a frame's centroid follows its totals through the queue, the divider and the result register
// throughput: one pixel per cycle unless full; the 10-step shared divider takes one frame at a time
// the input stalls only while two frame totals wait in the queue for the divider
// reset (synchronous, active low) clears accumulators and queues, sets blue_ratio to 5
module color_blob_centroid_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  cbc_pkg::pixel_t                 in_data,
  output logic                            empty,
  input  logic                            pop,
  output cbc_pkg::centroid_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cbc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [cbc_pkg::RATIO_W-1:0] ratio_r;
  logic                        hit;
  cbc_pkg::q_wr_t              q_wr;
  cbc_pkg::q_stat_t            q_stat;
  cbc_pkg::totals_t            rd_data;
  logic                        rd_en;

  // register decode: word addressed
  assign pready = 1'b1;
  assign hit    = ({paddr[cbc_pkg::CFG_ADDR_W-1:2], 2'b00} == cbc_pkg::REG_BLUE_RATIO);
  assign prdata = hit ? cbc_pkg::CFG_DATA_W'(ratio_r) : '0;

  // blue ratio register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= cbc_pkg::RATIO_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      ratio_r <= pwdata[cbc_pkg::RATIO_W-1:0];
    end
  end

  // classify and accumulate
  cbc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ratio   (ratio_r),
    .push    (push),
    .in_data (in_data),
    .q_stat  (q_stat),
    .full    (full),
    .q_wr    (q_wr)
  );

  // frame totals queue
  cbc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .q_stat  (q_stat)
  );

  // divide and deliver
  cbc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .rd_data  (rd_data),
    .rd_en    (rd_en),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// ----- tb/color_blob_centroid_unit_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the color blob centroid unit
module color_blob_centroid_unit_test;
  import cbc_pkg::*;

  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            push = 1'b0;
  logic            full;
  pixel_t          in_data = '0;
  logic            empty;
  logic            pop = 1'b0;
  centroid_t       out_data;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic            pready;

  // predictor state
  logic [RATIO_W-1:0] model_ratio;
  logic [SUM_W-1:0]   model_sum_col;
  logic [SUM_W-1:0]   model_sum_row;
  logic [COUNT_W-1:0] model_hits;

  centroid_t pending_centroids[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      recv_hold = 1'b0;
  int        quiet_cycles = 0;

  color_blob_centroid_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accumulate one accepted pixel and queue the centroid at the frame end
  task automatic predict_centroid(input pixel_t p);
    int        lim;
    bit        hit;
    centroid_t c;
    lim = int'(model_ratio);
    hit = (int'(p.blue) > lim * int'(p.red)) && (int'(p.blue) > lim * int'(p.green));
    if (hit && (longint'(model_hits) < longint'(MATCH_CAP))) begin
      model_sum_col = model_sum_col + SUM_W'(p.column);
      model_sum_row = model_sum_row + SUM_W'(p.row);
      model_hits    = model_hits + 1'b1;
    end
    if (p.last_pixel) begin
      if (model_hits != 0) begin
        c.found    = 1'b1;
        c.centre_x = COORD_W'(model_sum_col / model_hits);
        c.centre_y = COORD_W'(model_sum_row / model_hits);
      end else begin
        c = '0;
      end
      pending_centroids.push_back(c);
      model_sum_col = '0;
      model_sum_row = '0;
      model_hits    = '0;
    end
  endtask

  // offer one pixel request, with random idle cycles before it
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (full);
    predict_centroid(p);
  endtask

  function automatic pixel_t mk_pixel(input int r, input int g, input int b,
                                      input int col, input int row, input bit last);
    pixel_t p;
    p.red        = COLOR_W'(r);
    p.green      = COLOR_W'(g);
    p.blue       = COLOR_W'(b);
    p.column     = COORD_W'(col);
    p.row        = COORD_W'(row);
    p.last_pixel = last;
    return p;
  endfunction

  // wait until every centroid has come out and the divider has drained
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_centroids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb read of the ratio register, compared with the predictor copy
  task automatic check_ratio_reg();
    logic [CFG_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_BLUE_RATIO;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== CFG_DATA_W'(model_ratio)) begin
      $display("%0t: blue_ratio read expected %0h actual %0h", $time, model_ratio, got);
      errors++;
    end
  endtask

  // apb write of the ratio register, upper data bits random
  task automatic write_ratio(input int val);
    logic [CFG_DATA_W-1:0] w;
    wait_idle();
    w = $urandom();
    w[RATIO_W-1:0] = RATIO_W'(val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_BLUE_RATIO;
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_ratio = RATIO_W'(val);
    @(posedge clk);
    check_ratio_reg();
  endtask

  // result side: check each popped centroid, then pick the next pop
  always @(posedge clk) begin
    centroid_t want;
    if (rst_n && pop && !empty) begin
      if (pending_centroids.size() == 0) begin
        $display("%0t: unexpected centroid found=%0b x=%0d y=%0d", $time,
                 out_data.found, out_data.centre_x, out_data.centre_y);
        errors++;
      end else begin
        want = pending_centroids.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_data.found);
          errors++;
        end
        if (out_data.centre_x !== want.centre_x) begin
          $display("%0t: centre_x expected %0d actual %0d", $time,
                   want.centre_x, out_data.centre_x);
          errors++;
        end
        if (out_data.centre_y !== want.centre_y) begin
          $display("%0t: centre_y expected %0d actual %0d", $time,
                   want.centre_y, out_data.centre_y);
          errors++;
        end
      end
    end
    if (!rst_n) pop <= 1'b0;
    else        pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset value readback, then both extremes and back
  task automatic test_register_access();
    check_ratio_reg();
    write_ratio(15);
    write_ratio(0);
    write_ratio(5);
  endtask

  // strict comparisons, empty frames, coordinate extremes, truncation
  task automatic test_directed_extremes();
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 1));           // nothing matches
    send_pixel(mk_pixel(0, 0, 255, 1023, 1023, 1));   // largest coordinates
    send_pixel(mk_pixel(0, 0, 1, 0, 0, 1));           // smallest match at origin
    send_pixel(mk_pixel(10, 0, 50, 300, 300, 1));     // blue equals ratio * red
    send_pixel(mk_pixel(10, 10, 51, 100, 7, 0));
    send_pixel(mk_pixel(0, 11, 51, 900, 900, 0));     // green blocks the match
    send_pixel(mk_pixel(255, 255, 255, 512, 512, 0));
    send_pixel(mk_pixel(0, 0, 200, 1, 2, 0));
    send_pixel(mk_pixel(0, 0, 200, 2, 5, 1));         // mean truncates
    send_pixel(mk_pixel(255, 255, 255, 1023, 0, 1));
  endtask

  // with ratio zero any nonzero blue matches
  task automatic test_ratio_zero();
    write_ratio(0);
    send_pixel(mk_pixel(255, 255, 0, 1023, 1023, 0));
    send_pixel(mk_pixel(255, 255, 1, 5, 6, 1));
    send_pixel(mk_pixel(0, 0, 0, 7, 7, 1));
  endtask

  // largest ratio
  task automatic test_ratio_max();
    write_ratio(15);
    send_pixel(mk_pixel(16, 16, 255, 640, 480, 0));
    send_pixel(mk_pixel(17, 0, 255, 10, 10, 0));
    send_pixel(mk_pixel(0, 17, 255, 20, 20, 0));
    send_pixel(mk_pixel(16, 16, 241, 641, 481, 1));
  endtask

  function automatic pixel_t rand_pixel(input bit last);
    pixel_t p;
    int     b;
    int     cap;
    p.red        = COLOR_W'($urandom_range(255));
    p.green      = COLOR_W'($urandom_range(255));
    p.blue       = COLOR_W'($urandom_range(255));
    p.column     = COORD_W'($urandom_range(1023));
    p.row        = COORD_W'($urandom_range(1023));
    p.last_pixel = last;
    // half the pixels lean toward a match, up to the threshold itself
    if ($urandom_range(1)) begin
      b = $urandom_range(255);
      cap = (model_ratio == 0) ? 255 : b / int'(model_ratio);
      p.blue  = COLOR_W'(b);
      p.red   = COLOR_W'($urandom_range(cap));
      p.green = COLOR_W'($urandom_range(cap));
    end
    return p;
  endfunction

  // random frames, mostly short
  task automatic test_random_frames(input int target, input int s_pct, input int r_pct);
    int sent;
    int len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_pixel(rand_pixel(i == len - 1));
      sent += len;
    end
  endtask

  // receiver holds off while single-pixel frames keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 80; i++) send_pixel(rand_pixel(1'b1));
  endtask

  // test sequence
  initial begin
    model_ratio   = RATIO_RESET;
    model_sum_col = '0;
    model_sum_row = '0;
    model_hits    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_directed_extremes();
    test_ratio_zero();
    test_ratio_max();

    write_ratio(3);
    test_random_frames(700, 37, 61);
    write_ratio(1);
    test_random_frames(700, 61, 37);
    write_ratio($urandom_range(15));
    test_random_frames(600, 0, 0);
    write_ratio(2);
    test_backpressure();

    push <= 1'b0;
    recv_idle_pct = 0;
    while (pending_centroids.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
